// ----- hw/rtl/hnm_pkg.sv -----
// ----------------------------------------------------------------------------
// hnm_pkg
// shared types, codes and constants of the height-grid normal-map block
// ----------------------------------------------------------------------------
package hnm_pkg;

  // input request: write a height or query the normal at a cell
  typedef struct packed {
    logic        kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] height;
  } hnm_in_t;

  typedef struct packed {
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic [15:0] color_r;
    logic [15:0] color_g;
    logic [15:0] color_b;
  } hnm_out_t;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_RADIUS      = 3'd2,
    CFG_SCALE_X     = 3'd3,
    CFG_SCALE_Y     = 3'd4,
    CFG_FLIP        = 3'd5,
    CFG_Y_UP        = 3'd6
  } hnm_cfg_idx_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_WRITE,
    OP_SETUP,
    OP_READ,
    OP_MUL,
    OP_LOAD_SLOPE,
    OP_DIV_STEP,
    OP_STORE_MAG,
    OP_SHIFT,
    OP_SQUARE,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_LOAD_ENC,
    OP_STORE_ENC,
    OP_FINISH
  } hnm_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SLOPE_LOAD,
    ST_SLOPE_DIV,
    ST_SLOPE_STORE,
    ST_NORM,
    ST_SQUARE,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_ENC_LOAD,
    ST_ENC_DIV,
    ST_ENC_STORE,
    ST_FINISH,
    ST_DONE
  } hnm_state_e;

  typedef struct packed {
    hnm_op_e    op;
    logic [5:0] step;
    logic [1:0] item;
  } hnm_cmd_t;

  typedef struct packed {
    logic over_limit;
  } hnm_sts_t;

  localparam logic [5:0] READ_LAST   = 6'd4;
  localparam logic [5:0] DIV_LAST    = 6'd48;
  localparam logic [5:0] SQUARE_LAST = 6'd3;
  localparam logic [5:0] SQRT_LAST   = 6'd31;
  localparam logic [1:0] AXIS_LAST   = 2'd1;
  localparam logic [1:0] ENC_LAST    = 2'd3;

  localparam logic [8:0]  GRID_MAX   = 9'd256;
  localparam logic [5:0]  RADIUS_MAX = 6'd32;
  localparam logic [33:0] ONE_Q16    = 34'd65536;

endpackage

// ----- hw/rtl/hnm_ctrl.sv -----
// ----------------------------------------------------------------------------
// hnm_ctrl
// sequencer: steps the datapath through read, slope, normalize, square, sqrt, encode
// ----------------------------------------------------------------------------
module hnm_ctrl import hnm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     kind_i,
  input  hnm_sts_t sts_i,
  output hnm_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  hnm_state_e state_q, state_d;
  logic [5:0] step_q, step_d;
  logic [1:0] item_q, item_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      item_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      item_q  <= item_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    item_d  = item_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i && kind_i == KIND_QUERY) begin
          state_d = ST_READ;
          step_d  = '0;
        end
      end
      ST_READ: begin
        if (step_q == READ_LAST) begin
          state_d = ST_MUL;
          item_d  = '0;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      ST_MUL: state_d = ST_SLOPE_LOAD;
      ST_SLOPE_LOAD: begin
        state_d = ST_SLOPE_DIV;
        step_d  = '0;
      end
      ST_SLOPE_DIV: begin
        if (step_q == DIV_LAST) state_d = ST_SLOPE_STORE;
        else step_d = step_q + 6'd1;
      end
      ST_SLOPE_STORE: begin
        if (item_q == AXIS_LAST) begin
          state_d = ST_NORM;
        end else begin
          item_d  = item_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_NORM: begin
        if (!sts_i.over_limit) begin
          state_d = ST_SQUARE;
          step_d  = '0;
        end
      end
      ST_SQUARE: begin
        if (step_q == SQUARE_LAST) state_d = ST_SQRT_INIT;
        else step_d = step_q + 6'd1;
      end
      ST_SQRT_INIT: begin
        state_d = ST_SQRT;
        step_d  = '0;
      end
      ST_SQRT: begin
        if (step_q == SQRT_LAST) begin
          state_d = ST_ENC_LOAD;
          item_d  = '0;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      ST_ENC_LOAD: begin
        state_d = ST_ENC_DIV;
        step_d  = '0;
      end
      ST_ENC_DIV: begin
        if (step_q == DIV_LAST) state_d = ST_ENC_STORE;
        else step_d = step_q + 6'd1;
      end
      ST_ENC_STORE: begin
        if (item_q == ENC_LAST) begin
          state_d = ST_FINISH;
        end else begin
          item_d  = item_q + 2'd1;
          state_d = ST_ENC_LOAD;
        end
      end
      ST_FINISH: state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_IDLE;
    cmd_o.step = step_q;
    cmd_o.item = item_q;
    busy_o     = (state_q != ST_IDLE);
    done_o     = (state_q == ST_DONE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) cmd_o.op = (kind_i == KIND_QUERY) ? OP_SETUP : OP_WRITE;
      end
      ST_READ:        cmd_o.op = OP_READ;
      ST_MUL:         cmd_o.op = OP_MUL;
      ST_SLOPE_LOAD:  cmd_o.op = OP_LOAD_SLOPE;
      ST_SLOPE_DIV:   cmd_o.op = OP_DIV_STEP;
      ST_SLOPE_STORE: cmd_o.op = OP_STORE_MAG;
      ST_NORM:        cmd_o.op = OP_SHIFT;
      ST_SQUARE:      cmd_o.op = OP_SQUARE;
      ST_SQRT_INIT:   cmd_o.op = OP_SQRT_INIT;
      ST_SQRT:        cmd_o.op = OP_SQRT_STEP;
      ST_ENC_LOAD:    cmd_o.op = OP_LOAD_ENC;
      ST_ENC_DIV:     cmd_o.op = OP_DIV_STEP;
      ST_ENC_STORE:   cmd_o.op = OP_STORE_ENC;
      ST_FINISH:      cmd_o.op = OP_FINISH;
      default:        cmd_o.op = OP_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/hnm_dp.sv -----
// ----------------------------------------------------------------------------
// hnm_dp
// datapath: height memory, config registers, shared divider, sqrt, encoder
// ----------------------------------------------------------------------------
module hnm_dp import hnm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  hnm_in_t     in_i,
  input  hnm_cmd_t    cmd_i,
  output hnm_sts_t    sts_o,
  output hnm_out_t    res_o
);

  // configuration
  logic [8:0]  gw_q, gh_q;
  logic [5:0]  rad_q;
  logic [31:0] scx_q, scy_q;
  logic        flip_q, yup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q   <= GRID_MAX;
      gh_q   <= GRID_MAX;
      rad_q  <= 6'd1;
      scx_q  <= 32'd65536;
      scy_q  <= 32'd65536;
      flip_q <= 1'b0;
      yup_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  gw_q   <= cfg_wdata_i[8:0];
        CFG_GRID_HEIGHT: gh_q   <= cfg_wdata_i[8:0];
        CFG_RADIUS:      rad_q  <= cfg_wdata_i[5:0];
        CFG_SCALE_X:     scx_q  <= cfg_wdata_i;
        CFG_SCALE_Y:     scy_q  <= cfg_wdata_i;
        CFG_FLIP:        flip_q <= cfg_wdata_i[0];
        CFG_Y_UP:        yup_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // neighbour coordinates, clamped to grid in use
  logic [8:0] w_c, h_c;
  logic [5:0] r_c;
  logic [7:0] wl_c, hl_c, colc_c, rowc_c;
  logic [8:0] colr_c, rowr_c;
  logic [7:0] xl_c, xr_c, yd_c, yu_c;

  always_comb begin
    w_c    = (gw_q == 9'd0) ? 9'd1 : ((gw_q > GRID_MAX) ? GRID_MAX : gw_q);
    h_c    = (gh_q == 9'd0) ? 9'd1 : ((gh_q > GRID_MAX) ? GRID_MAX : gh_q);
    r_c    = (rad_q == 6'd0) ? 6'd1 : ((rad_q > RADIUS_MAX) ? RADIUS_MAX : rad_q);
    wl_c   = 8'(w_c - 9'd1);
    hl_c   = 8'(h_c - 9'd1);
    colc_c = (in_i.col > wl_c) ? wl_c : in_i.col;
    rowc_c = (in_i.row > hl_c) ? hl_c : in_i.row;
    xl_c   = (colc_c > {2'b0, r_c}) ? 8'(colc_c - {2'b0, r_c}) : 8'd0;
    yd_c   = (rowc_c > {2'b0, r_c}) ? 8'(rowc_c - {2'b0, r_c}) : 8'd0;
    colr_c = {1'b0, colc_c} + {3'b0, r_c};
    rowr_c = {1'b0, rowc_c} + {3'b0, r_c};
    xr_c   = (colr_c > {1'b0, wl_c}) ? wl_c : colr_c[7:0];
    yu_c   = (rowr_c > {1'b0, hl_c}) ? hl_c : rowr_c[7:0];
  end

  logic [7:0]  col_q, row_q, xl_q, xr_q, yd_q, yu_q;
  logic [6:0]  spx_q, spy_q;

  // height memory, address {row, col}
  logic [15:0] mem_q [65536];
  logic [15:0] mrd_q;
  logic [15:0] waddr_c, raddr_c;
  logic [15:0] h_q [4];

  assign waddr_c = {in_i.row, in_i.col};

  always_comb begin
    case (cmd_i.step[1:0])
      2'd0:    raddr_c = {row_q, xl_q};
      2'd1:    raddr_c = {row_q, xr_q};
      2'd2:    raddr_c = {yd_q, col_q};
      default: raddr_c = {yu_q, col_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE) mem_q[waddr_c] <= in_i.height;
    mrd_q <= mem_q[raddr_c];
  end

  // slope terms
  logic [15:0] near_c, far_c, dh_c;
  logic [6:0]  span_c;
  logic [31:0] scale_c;
  logic [47:0] prod_q;
  logic [22:0] den_q;
  logic        zero_q;
  logic        neg_q;
  logic [33:0] m_q [3];
  logic        s_q [2];

  always_comb begin
    near_c  = cmd_i.item[0] ? h_q[2] : h_q[0];
    far_c   = cmd_i.item[0] ? h_q[3] : h_q[1];
    span_c  = cmd_i.item[0] ? spy_q : spx_q;
    scale_c = cmd_i.item[0] ? scy_q : scx_q;
    dh_c    = (far_c > near_c) ? (far_c - near_c) : (near_c - far_c);
  end

  // shared restoring divider, one quotient bit a cycle
  logic [32:0] dden_q, rem_q;
  logic [48:0] quo_q;
  logic [33:0] rem_sh_c;

  assign rem_sh_c = {rem_q, quo_q[48]};

  // normalize, square, sqrt
  logic [61:0] sq_q, acc_q;
  logic [29:0] sqm_c;
  logic [61:0] v_q;
  logic [62:0] res_q, bit_q;
  logic [63:0] trial_c;
  logic [31:0] len_c;

  assign sts_o.over_limit = (|m_q[0][33:30]) | (|m_q[1][33:30]) | (|m_q[2][33:30]);

  always_comb begin
    case (cmd_i.step[1:0])
      2'd0:    sqm_c = m_q[0][29:0];
      2'd1:    sqm_c = m_q[1][29:0];
      default: sqm_c = m_q[2][29:0];
    endcase
  end

  assign trial_c = {1'b0, res_q} + {1'b0, bit_q};
  assign len_c   = (res_q[31:0] == 32'd0) ? 32'd1 : res_q[31:0];

  // encoder operands
  logic [33:0] em_c, emc_c;
  logic        eneg_c;
  logic [32:0] t_c;
  logic [48:0] enum_c;
  logic [15:0] enc_q [4];

  always_comb begin
    case (cmd_i.item)
      2'd0: begin
        em_c   = m_q[0];
        eneg_c = s_q[0];
      end
      2'd1: begin
        em_c   = m_q[1];
        eneg_c = s_q[1];
      end
      2'd2: begin
        em_c   = m_q[1];
        eneg_c = !s_q[1];
      end
      default: begin
        em_c   = m_q[2];
        eneg_c = 1'b0;
      end
    endcase
    emc_c  = (em_c > {2'b0, len_c}) ? {2'b0, len_c} : em_c;
    t_c    = eneg_c ? ({1'b0, len_c} - emc_c[32:0]) : ({1'b0, len_c} + emc_c[32:0]);
    enum_c = {t_c, 16'd0} - {16'd0, t_c} + {17'd0, len_c};
  end

  logic [15:0] yfin_c;
  hnm_out_t    out_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_SETUP: begin
        col_q <= colc_c;
        row_q <= rowc_c;
        xl_q  <= xl_c;
        xr_q  <= xr_c;
        yd_q  <= yd_c;
        yu_q  <= yu_c;
        spx_q <= 7'(xr_c - xl_c);
        spy_q <= 7'(yu_c - yd_c);
      end
      OP_READ: begin
        if (cmd_i.step != 6'd0) h_q[cmd_i.step[1:0] - 2'd1] <= mrd_q;
      end
      OP_MUL: begin
        prod_q <= {16'd0, scale_c} * {32'd0, dh_c};
        den_q  <= {span_c, 16'd0} - {16'd0, span_c};
        zero_q <= (span_c == 7'd0);
        neg_q  <= (far_c > near_c);
      end
      OP_LOAD_SLOPE: begin
        quo_q  <= {1'b0, prod_q} + {27'd0, den_q[22:1]};
        dden_q <= {10'd0, den_q};
        rem_q  <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_sh_c >= {1'b0, dden_q}) begin
          rem_q <= 33'(rem_sh_c - {1'b0, dden_q});
          quo_q <= {quo_q[47:0], 1'b1};
        end else begin
          rem_q <= rem_sh_c[32:0];
          quo_q <= {quo_q[47:0], 1'b0};
        end
      end
      OP_STORE_MAG: begin
        m_q[{1'b0, cmd_i.item[0]}] <= zero_q ? 34'd0 : quo_q[33:0];
        s_q[cmd_i.item[0]]         <= zero_q ? 1'b0 : neg_q;
        m_q[2]                     <= ONE_Q16;
      end
      OP_SHIFT: begin
        if (sts_o.over_limit) begin
          m_q[0] <= m_q[0] >> 1;
          m_q[1] <= m_q[1] >> 1;
          m_q[2] <= m_q[2] >> 1;
        end
      end
      OP_SQUARE: begin
        if (cmd_i.step != SQUARE_LAST) sq_q <= 62'(sqm_c) * 62'(sqm_c);
        if (cmd_i.step == 6'd0) acc_q <= '0;
        else acc_q <= acc_q + sq_q;
      end
      OP_SQRT_INIT: begin
        v_q   <= acc_q;
        res_q <= '0;
        bit_q <= 63'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if ({2'b0, v_q} >= trial_c) begin
          v_q   <= 62'({2'b0, v_q} - trial_c);
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_LOAD_ENC: begin
        quo_q  <= enum_c;
        dden_q <= {len_c, 1'b0};
        rem_q  <= '0;
      end
      OP_STORE_ENC: begin
        enc_q[cmd_i.item] <= (|quo_q[48:16]) ? 16'hFFFF : quo_q[15:0];
      end
      OP_FINISH: begin
        out_q.normal_x <= enc_q[0];
        out_q.normal_y <= enc_q[1];
        out_q.normal_z <= enc_q[3];
        out_q.color_r  <= enc_q[0];
        out_q.color_g  <= yup_q ? enc_q[3] : yfin_c;
        out_q.color_b  <= yup_q ? yfin_c : enc_q[3];
      end
      default: ;
    endcase
  end

  // export y after optional handedness flip
  assign yfin_c = flip_q ? enc_q[2] : enc_q[1];
  assign res_o  = out_q;

endmodule

// ----- hw/rtl/heightmap_normal_map.sv -----
// ----------------------------------------------------------------------------
// heightmap_normal_map
// height grid with central-difference normal and colour export per query
// ----------------------------------------------------------------------------
// usage
//   requests enter on start_i with req_i while busy_o is low
//   a write request (kind 0) stores one height in the same cycle and leaves
//   busy_o low, so writes go back to back at one per cycle
//   a query request (kind 1) raises busy_o and, when it completes, raises
//   done_o for exactly one cycle with the result on result_o; the next
//   request is taken in the cycle after the done_o cycle
//   a query steps through memory reads on the single read port, two slope
//   divisions, a normalize step with shifts as needed, the squares, a
//   square root and four encode divisions on one shared
//   divider
//   config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once and
//   are expected only while busy_o is low
//   reset restores the config defaults and the idle state; the height memory
//   keeps no reset and must be written before it is queried
//   the receiver cannot stall: a result is valid for the done_o cycle only
// ----------------------------------------------------------------------------
module heightmap_normal_map import hnm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  hnm_in_t     req_i,
  output logic        busy_o,
  output logic        done_o,
  output hnm_out_t    result_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  // command and status between sequencer and datapath
  hnm_cmd_t cmd;
  hnm_sts_t sts;

  hnm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (req_i.kind),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  hnm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (result_o)
  );

endmodule
